// ===== design/npps_pkg.sv =====
// Package for the nearest phase preset search: types, sizes and the sine table.
`timescale 1ns / 1ps

package npps_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int VECTOR_BITS = 16;
    localparam int FRAC_BITS   = VECTOR_BITS - 2;
    localparam int ROUND_SHIFT = 30 - FRAC_BITS;
    localparam int COUNT_BITS  = 9;
    localparam int DEG_BITS    = 9;
    localparam int DIST_BITS   = 32;
    localparam int QUARTER_LEN = 91;

    localparam logic [63:0]          PI_Q30   = 64'd3373259426;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // command codes on the input tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic                 load_en;
        logic                 start_query;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

    typedef logic [QUARTER_LEN-1:0][VECTOR_BITS-1:0] t_qsine;

    // quarter-wave sine, 0..90 degrees, Taylor series in Q30 then rounded
    function automatic t_qsine f_build_qsine();
        t_qsine      tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          k;
        int          n;
        for (k = 0; k < QUARTER_LEN; k++) begin
            x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = VECTOR_BITS'((64'(sum) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
        end
        return tab;
    endfunction

    localparam t_qsine QSINE = f_build_qsine();

    // full-wave sine by symmetry, d already reduced below 360
    function automatic logic signed [VECTOR_BITS-1:0] f_rom_sine(input logic [DEG_BITS-1:0] d);
        logic signed [VECTOR_BITS-1:0] v;
        if (d <= 9'd90) begin
            v = QSINE[7'(d)];
        end else if (d <= 9'd180) begin
            v = QSINE[7'(9'd180 - d)];
        end else if (d <= 9'd270) begin
            v = -QSINE[7'(d - 9'd180)];
        end else begin
            v = -QSINE[7'(9'd360 - d)];
        end
        return v;
    endfunction

endpackage

// ===== design/npps_dp.sv =====
// Datapath: preset memory, target sine/cosine, distance pipeline and best tracker.
`timescale 1ns / 1ps

module npps_dp
    import npps_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctrl_cmd                     i_cmd,
    input  logic [ADDR_BITS-1:0]          i_entry_index,
    input  logic [VECTOR_BITS-1:0]        i_entry_i,
    input  logic [VECTOR_BITS-1:0]        i_entry_q,
    input  logic [DEG_BITS-1:0]           i_target_deg,
    output t_dp_status                    o_status,
    output logic [ADDR_BITS-1:0]          o_best_index,
    output logic [DIST_BITS-1:0]          o_best_distance
);

    logic [2*VECTOR_BITS-1:0] r_mem [0:TABLE_DEPTH-1];
    logic [2*VECTOR_BITS-1:0] r_rdata;

    logic signed [VECTOR_BITS:0] r_ts, r_tc;
    logic [DEG_BITS-1:0]         w_deg;
    logic [DEG_BITS:0]           w_cdeg_raw;
    logic [DEG_BITS-1:0]         w_cdeg;
    logic signed [VECTOR_BITS-1:0] w_ts, w_tc;

    logic                        r_v1, r_v2, r_v3;
    logic [ADDR_BITS-1:0]        r_idx1, r_idx2, r_idx3;
    logic signed [VECTOR_BITS:0] r_di, r_dq;
    logic signed [VECTOR_BITS:0] w_ei, w_eq;
    logic [DIST_BITS-1:0]        r_sqi, r_sqq;
    logic signed [2*VECTOR_BITS+1:0] w_pi, w_pq;
    logic [DIST_BITS:0]          w_sum;
    logic [DIST_BITS-1:0]        w_dist;

    logic [ADDR_BITS-1:0]        r_best_idx;
    logic [DIST_BITS-1:0]        r_best_dist;
    logic [ADDR_BITS-1:0]        r_out_idx;
    logic [DIST_BITS-1:0]        r_out_dist;

    // preset memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_mem[i_entry_index] <= {i_entry_i, i_entry_q};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_addr];
        end
    end

    // angle reduction and ROM lookup
    always_comb begin
        w_deg      = (i_target_deg >= 9'd360) ? (i_target_deg - 9'd360) : i_target_deg;
        w_cdeg_raw = {1'b0, w_deg} + 10'd90;
        w_cdeg     = (w_cdeg_raw >= 10'd360) ? 9'(w_cdeg_raw - 10'd360) : 9'(w_cdeg_raw);
        w_ts       = f_rom_sine(w_deg);
        w_tc       = f_rom_sine(w_cdeg);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_ts <= {w_ts[VECTOR_BITS-1], w_ts};
            r_tc <= {w_tc[VECTOR_BITS-1], w_tc};
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // differences to the target
    assign w_ei = {r_rdata[2*VECTOR_BITS-1], r_rdata[2*VECTOR_BITS-1:VECTOR_BITS]};
    assign w_eq = {r_rdata[VECTOR_BITS-1], r_rdata[VECTOR_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_cmd.rd_addr;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_di   <= w_ei - r_tc;
        r_dq   <= w_eq - r_ts;
    end

    // squares, one multiplier per axis
    assign w_pi = r_di * r_di;
    assign w_pq = r_dq * r_dq;

    always_ff @(posedge i_clk) begin
        r_sqi <= w_pi[DIST_BITS-1:0];
        r_sqq <= w_pq[DIST_BITS-1:0];
    end

    // saturating sum and running minimum, strict compare keeps the first
    assign w_sum  = {1'b0, r_sqi} + {1'b0, r_sqq};
    assign w_dist = w_sum[DIST_BITS] ? DIST_MAX : w_sum[DIST_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_best_idx  <= '0;
            r_best_dist <= DIST_MAX;
        end else if (r_v3 && (w_dist < r_best_dist)) begin
            r_best_idx  <= r_idx3;
            r_best_dist <= w_dist;
        end
        if (i_cmd.out_load) begin
            r_out_idx  <= r_best_idx;
            r_out_dist <= r_best_dist;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_best_index       = r_out_idx;
    assign o_best_distance    = r_out_dist;

endmodule

// ===== design/npps_ctrl.sv =====
// Controller: count register, scan sequencer and output word valid.
`timescale 1ns / 1ps

module npps_ctrl
    import npps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [COUNT_BITS-1:0] i_cfg_wr_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  t_dp_status            i_status,
    output t_ctrl_cmd             o_cmd
);

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_preset_count;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [COUNT_BITS-1:0] r_addr, n_addr;
    logic                  r_out_valid, n_out_valid;
    logic                  w_accept;
    logic [COUNT_BITS-1:0] w_clamped;

    assign w_clamped = (r_preset_count > COUNT_BITS'(TABLE_DEPTH)) ?
                       COUNT_BITS'(TABLE_DEPTH) : r_preset_count;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_preset_count <= i_cfg_wr_data;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_addr = r_addr[ADDR_BITS-1:0];
        w_accept    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_accept   = i_in_valid;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_LOAD) begin
                        o_cmd.load_en = 1'b1;
                    end else begin
                        o_cmd.start_query = 1'b1;
                        n_count = w_clamped;
                        n_addr  = '0;
                        n_state = (w_clamped == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = r_addr + 1'b1;
                if ((r_addr + 1'b1) == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // checks on the sequencer
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_addr < r_count))
        else $error("read issued past the scan count");

    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_state == S_SCAN))
        else $error("read issued outside the scan");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before taken");

    a_done_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_status.pipe_busy)
        else $error("result loaded while pipeline still busy");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_state == S_IDLE))
        else $error("input accepted outside idle");

endmodule

// ===== design/nearest_phase_preset_search_top.sv =====
// Top level of the nearest phase preset search.
//
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready tdata: entry_index, entry_i, entry_q,
//                                                  target_deg; tuser: command
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready tdata: best_index, best_distance
// cfg       in   i_cfg_wr_en                       i_cfg_wr_data: preset_count
//
// A load word is written into the preset memory as it is taken. In a query, N = min(preset_count, 256):
// the single read port of the preset memory feeds one entry per cycle into a
// four-stage distance pipeline. An empty table gives a result with no scan.
// Reset is synchronous and active low; the table content is kept across it.
// A result waits in the output register while the next load or query is taken.
`timescale 1ns / 1ps

module nearest_phase_preset_search_top
    import npps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] entry_index, [23:8] entry_i, [39:24] entry_q, [48:40] target_deg, [55:49] zero
    input  logic [55:0] i_s_axis_tdata,
    // [0] command
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] best_index, [39:8] best_distance
    output logic [39:0] o_m_axis_tdata
);

    t_ctrl_cmd            w_cmd;
    t_dp_status           w_status;
    logic [ADDR_BITS-1:0] w_best_index;
    logic [DIST_BITS-1:0] w_best_distance;

    npps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .i_in_cmd      (i_s_axis_tuser),
        .o_in_ready    (o_s_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    npps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_entry_index   (i_s_axis_tdata[7:0]),
        .i_entry_i       (i_s_axis_tdata[23:8]),
        .i_entry_q       (i_s_axis_tdata[39:24]),
        .i_target_deg    (i_s_axis_tdata[48:40]),
        .o_status        (w_status),
        .o_best_index    (w_best_index),
        .o_best_distance (w_best_distance)
    );

    assign o_m_axis_tdata = {w_best_distance, w_best_index};

endmodule

// ===== verif/nearest_phase_preset_search_checker.sv =====
// Checker for the nearest phase preset search: predicts each query result and compares it.
`timescale 1ns / 1ps

module nearest_phase_preset_search_checker
    import npps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // [7:0] entry_index, [23:8] entry_i, [39:24] entry_q, [48:40] target_deg, [55:49] zero
    input  logic [55:0] i_s_axis_tdata,
    // [0] command
    input  logic        i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] best_index, [39:8] best_distance
    input  logic [39:0] i_m_axis_tdata,
    output int          o_errors,
    output int          o_queries,
    output int          o_results
);

    localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
    localparam int              Q14_SHIFT     = 16;
    localparam longint          DIST_TOP      = 64'hFFFF_FFFF;
    localparam int              MAX_SCAN      = 256;
    localparam int              REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] sq_dist;
    } t_best;

    // shadow of the preset table and the scan length register
    logic signed [15:0] preset_i [MAX_SCAN];
    logic signed [15:0] preset_q [MAX_SCAN];
    logic [8:0]         scan_len;
    int                 quarter_wave [91];
    t_best              best_fifo [$];
    int                 err_n = 0;
    int                 qry_n = 0;
    int                 res_n = 0;

    // quarter-wave sine in Q1.14: Taylor series in Q30, rounded to nearest
    initial begin
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= 90; k++) begin
            ang    = (longint'(k) * HALF_TURN_Q30 + 64'd90) / 64'd180;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            quarter_wave[k] = int'((acc + 64'd32768) >> Q14_SHIFT);
        end
    end

    function automatic int sine_q14(input int d);
        if (d <= 90) begin
            return quarter_wave[d];
        end else if (d <= 180) begin
            return quarter_wave[180 - d];
        end else if (d <= 270) begin
            return -quarter_wave[d - 180];
        end
        return -quarter_wave[360 - d];
    endfunction

    // argmin of squared distance over the scanned entries, first index on ties
    function automatic t_best nearest_preset(input logic [8:0] deg);
        t_best  best;
        int     d;
        int     tgt_s;
        int     tgt_c;
        int     n;
        longint di;
        longint dq;
        longint cand_dist;
        longint best_dist;
        d         = int'(deg) % 360;
        tgt_s     = sine_q14(d);
        tgt_c     = sine_q14((d + 90) % 360);
        n         = (scan_len > MAX_SCAN) ? MAX_SCAN : int'(scan_len);
        best_dist = DIST_TOP;
        best.idx  = 8'd0;
        for (int i = 0; i < n; i++) begin
            di        = longint'(preset_i[i]) - tgt_c;
            dq        = longint'(preset_q[i]) - tgt_s;
            cand_dist = di * di + dq * dq;
            if (cand_dist > DIST_TOP) begin
                cand_dist = DIST_TOP;
            end
            if (cand_dist < best_dist) begin
                best_dist = cand_dist;
                best.idx  = 8'(i);
            end
        end
        best.sq_dist = 32'(best_dist);
        return best;
    endfunction

    // watch config, input and output channels
    always @(posedge i_clk) begin : watch
        t_best want;
        t_best got;
        if (!i_rst_n) begin
            scan_len = '0;
            best_fifo.delete();
        end else begin
            if (i_cfg_wr_en) begin
                scan_len = i_cfg_wr_data;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (i_s_axis_tuser == CMD_QUERY) begin
                    best_fifo = {best_fifo, nearest_preset(i_s_axis_tdata[48:40])};
                    qry_n++;
                end else begin
                    preset_i[i_s_axis_tdata[7:0]] = i_s_axis_tdata[23:8];
                    preset_q[i_s_axis_tdata[7:0]] = i_s_axis_tdata[39:24];
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                res_n++;
                got.idx     = i_m_axis_tdata[7:0];
                got.sq_dist = i_m_axis_tdata[39:8];
                if (best_fifo.size() == 0) begin
                    err_n++;
                    if (err_n <= REPORT_LIMIT) begin
                        $display("result word %0d with no query waiting: index %0d distance %h",
                                 res_n, got.idx, got.sq_dist);
                    end
                end else begin
                    want = best_fifo.pop_front();
                    if (got !== want) begin
                        err_n++;
                        if (err_n <= REPORT_LIMIT) begin
                            $display("result word %0d: index exp %0d got %0d, distance exp %h got %h",
                                     res_n, want.idx, got.idx, want.sq_dist, got.sq_dist);
                        end
                    end
                end
            end
        end
        o_errors  <= err_n;
        o_queries <= qry_n;
        o_results <= res_n;
    end

endmodule

// ===== verif/nearest_phase_preset_search_top_tb.sv =====
// Testbench top for the nearest phase preset search: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module nearest_phase_preset_search_top_tb;
    import npps_pkg::*;

    localparam int ITEMS        = 1550;
    localparam int LIMIT        = 2000000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int SETTLE       = 16;
    localparam int END_SETTLE   = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_en;
    logic [8:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [55:0] s_data;
    logic        s_user;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;

    int          chk_errors;
    int          chk_queries;
    int          chk_results;

    bit          tx_idle  = 1'b1;
    bit          rx_idle;
    bit          rx_hold;
    bit          hold_req = 1'b0;
    int          n_load   = 0;
    int          n_query  = 0;
    int          cycle_count = 0;
    bit          saw_empty, saw_full, saw_over;

    // stimulus-side copy of loaded entries, used to plant ties
    logic [15:0] sh_i [256];
    logic [15:0] sh_q [256];
    bit          sh_ok [256];

    nearest_phase_preset_search_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    nearest_phase_preset_search_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_errors        (chk_errors),
        .o_queries       (chk_queries),
        .o_results       (chk_results)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("nearest_phase_preset_search_top_tb: errors");
            $finish;
        end
    end

    // result side: random wait after each word, long hold-off when asked
    initial begin
        int rx_wait;
        rx_wait = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (m_ready && m_valid) begin
                rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // hold-off stretch, counted here
    initial begin
        rx_hold <= 1'b0;
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // one input word, with a random gap ahead of it
    task automatic send_word(input logic cmd, input logic [7:0] idx, input logic [15:0] ei,
                             input logic [15:0] eq, input logic [8:0] deg);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {7'b0, deg, eq, ei, idx};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        if (cmd == CMD_QUERY) begin
            n_query++;
        end else begin
            n_load++;
        end
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [15:0] ei,
                              input logic [15:0] eq);
        sh_i[idx]  = ei;
        sh_q[idx]  = eq;
        sh_ok[idx] = 1'b1;
        send_word(CMD_LOAD, idx, ei, eq, 9'($urandom()));
    endtask

    task automatic query_angle(input logic [8:0] deg);
        send_word(CMD_QUERY, 8'($urandom()), 16'($urandom()), 16'($urandom()), deg);
    endtask

    // mostly in-range angles, some that wrap past 360
    function automatic logic [8:0] rand_deg();
        if ($urandom_range(0, 19) < 17) begin
            return 9'($urandom_range(0, 359));
        end
        return 9'($urandom_range(360, 511));
    endfunction

    // entry content: inside +-1.0, full range, or a copy of an entry to force ties
    task automatic pick_entry(output logic [15:0] ei, output logic [15:0] eq);
        int src;
        case ($urandom_range(0, 9))
            6, 7: begin
                ei = 16'($urandom());
                eq = 16'($urandom());
            end
            8, 9: begin
                src = $urandom_range(0, 255);
                if (sh_ok[src]) begin
                    ei = sh_i[src];
                    eq = sh_q[src];
                end else begin
                    ei = 16'(int'($urandom_range(0, 32768)) - 16384);
                    eq = 16'(int'($urandom_range(0, 32768)) - 16384);
                end
            end
            default: begin
                ei = 16'(int'($urandom_range(0, 32768)) - 16384);
                eq = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
        endcase
    endtask

    // stop offering, wait for every result, then let a trailing load finish
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge clk); while (chk_queries != chk_results);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(input logic [8:0] v);
        wait_drained();
        cfg_en   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_en   <= 1'b0;
        saw_empty |= (v == 9'd0);
        saw_full  |= (v == 9'd256);
        saw_over  |= (v > 9'd256);
    endtask

    initial begin
        logic [15:0] ei;
        logic [15:0] eq;
        logic [8:0]  nxt;
        int          len;
        int          phase;
        phase    = 0;
        rst_n    <= 1'b0;
        cfg_en   <= 1'b0;
        cfg_data <= '0;
        s_valid  <= 1'b0;
        s_user   <= CMD_LOAD;
        s_data   <= '0;
        rx_idle  <= 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, including a wrapped angle
        set_count(9'd0);
        query_angle(9'd0);
        query_angle(9'd511);

        // corner entries, an exact unit vector and its duplicate
        load_entry(8'd0, 16'h4000, 16'h0000);
        load_entry(8'd1, 16'h8000, 16'h8000);
        load_entry(8'd2, 16'h7FFF, 16'h7FFF);
        load_entry(8'd3, 16'h0000, 16'h4000);
        load_entry(8'd4, 16'h4000, 16'h0000);
        load_entry(8'd5, 16'h0000, 16'hC000);
        load_entry(8'd255, 16'hC000, 16'h4000);

        // quadrant edges, the tie at 0 degrees and a wrapped angle
        set_count(9'd6);
        query_angle(9'd0);
        query_angle(9'd90);
        query_angle(9'd180);
        query_angle(9'd270);
        query_angle(9'd359);
        query_angle(9'd360);
        query_angle(9'd45);
        query_angle(9'd225);
        set_count(9'd1);
        query_angle(9'd200);

        // fill the rest of the table, queries mixed in
        set_count(9'd6);
        for (int idx = 6; idx < 255; idx++) begin
            if ($urandom_range(0, 3) == 0) begin
                query_angle(rand_deg());
            end
            pick_entry(ei, eq);
            load_entry(8'(idx), ei, eq);
        end

        // random phases over scan lengths and pacing
        while (n_load + n_query < ITEMS) begin
            phase++;
            if (phase == 2) begin
                // receiver stalls, sender keeps pushing queries back to back
                set_count(9'd5);
                tx_idle  = 1'b0;
                hold_req = 1'b1;
                repeat (16) query_angle(rand_deg());
            end else begin
                case ($urandom_range(0, 9))
                    0:       nxt = 9'd0;
                    1:       nxt = 9'd1;
                    2:       nxt = 9'd256;
                    3:       nxt = 9'd511;
                    4:       nxt = 9'($urandom_range(257, 510));
                    5, 6, 7: nxt = 9'($urandom_range(2, 16));
                    default: nxt = 9'($urandom_range(17, 255));
                endcase
                set_count(nxt);
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle <= ($urandom_range(0, 3) != 0);
                len = $urandom_range(8, 40);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0) begin
                        pick_entry(ei, eq);
                        load_entry(8'($urandom_range(0, 255)), ei, eq);
                    end else begin
                        query_angle(rand_deg());
                    end
                end
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        $display("run covered %0d loads and %0d queries over %0d phases, %0d results checked",
                 n_load, n_query, phase, chk_results);
        $display("scan lengths tried: empty %0b, full table %0b, above table size %0b",
                 saw_empty, saw_full, saw_over);
        if (chk_errors == 0) begin
            $display("nearest_phase_preset_search_top_tb: clean");
        end else begin
            $display("nearest_phase_preset_search_top_tb: errors");
        end
        $finish;
    end

endmodule
